@@ hdl/swrm_pkg.sv @@
// ----------------------------------------------------------------------------
// swrm_pkg
// Shared types and constants for the sliding-window RMS level meter.
// ----------------------------------------------------------------------------
package swrm_pkg;

  // Ring depth. Must be a power of two: the mean is taken with a shift.
  localparam int WINDOW_DEPTH = 1024;
  localparam int AW           = $clog2(WINDOW_DEPTH);

  localparam int SAMPLE_W = 16;
  localparam int LEVEL_W  = 16;
  localparam int SQ_W     = 31;   // Q1.30 square of a Q1.15 sample
  localparam int SUM_W    = 41;   // Q11.30 sum of squares

  // Radicand of the square root: sum / window, padded to an even width and
  // never narrower than twice the level, so the root can always hold 1.0
  localparam int RAD_BITS = SUM_W - AW;
  localparam int RAD_W    = (RAD_BITS > 2 * LEVEL_W) ? RAD_BITS + (RAD_BITS % 2)
                                                     : 2 * LEVEL_W;
  localparam int ROOT_W = RAD_W / 2;
  localparam int REM_W  = ROOT_W + 2;
  localparam int CNT_W  = $clog2(ROOT_W);

  localparam logic [SUM_W-1:0]   SUM_MAX      = {SUM_W{1'b1}};
  localparam logic [SUM_W-1:0]   THRESH_RESET = SUM_W'(1073742);  // 0.001 in Q11.30
  localparam logic [LEVEL_W-1:0] LEVEL_ONE    = LEVEL_W'(32768);  // 1.0 in Q1.15

  // Request into the square root unit
  typedef struct packed {
    logic             start;
    logic [RAD_W-1:0] radicand;
  } swrm_sqrt_req_t;

  // Status and result of the square root unit
  typedef struct packed {
    logic              done;
    logic [ROOT_W-1:0] root;
  } swrm_sqrt_rsp_t;

endpackage

@@ hdl/swrm_sqrt.sv @@
// ----------------------------------------------------------------------------
// swrm_sqrt
// Iterative integer square root, one result bit per cycle (restoring method).
// ----------------------------------------------------------------------------
module swrm_sqrt import swrm_pkg::*; (
  input  logic           clk,
  input  logic           rst,
  input  swrm_sqrt_req_t req,
  output swrm_sqrt_rsp_t rsp
);

  logic             busy;
  logic             done;
  logic [CNT_W-1:0] cnt;
  logic [RAD_W-1:0] rad;
  logic [REM_W-1:0] rem;
  logic [ROOT_W-1:0] root;

  logic [REM_W+1:0] cand;
  logic [REM_W+1:0] trial;
  logic [REM_W+1:0] diff;

  // One digit step: bring down two radicand bits, try subtracting 4*root+1
  always_comb begin
    cand  = {rem, rad[RAD_W-1 -: 2]};
    trial = (REM_W+2)'({root, 2'b01});
    diff  = cand - trial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (req.start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= '0;
      rad  <= req.radicand;
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      rad <= rad << 2;
      if (cand >= trial) begin
        rem  <= diff[REM_W-1:0];
        root <= {root[ROOT_W-2:0], 1'b1};
      end else begin
        rem  <= cand[REM_W-1:0];
        root <= {root[ROOT_W-2:0], 1'b0};
      end
      cnt <= cnt + 1'b1;
      if (cnt == CNT_W'(ROOT_W - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  assign rsp.done = done;
  assign rsp.root = root;

endmodule

@@ hdl/sliding_window_rms_meter_top.sv @@
// ----------------------------------------------------------------------------
// sliding_window_rms_meter_top
// RMS level over a sliding window of squared audio samples.
// ----------------------------------------------------------------------------
// Each item is one Q1.15 sample and yields one Q1.15 RMS level, clamped to
// 1.0. The block works on one item at a time: a new item is taken only once
// the last one has passed the ring read, the sum update, the square root unit
// and the output load. The result sits in an output register, so the next
// item can be taken while the level waits to be read. Squares live in a
// 1024-entry ring memory with a registered read; no clearing pass is needed
// after reset, since a fill flag marks ring entries never written and those
// read as zero. The quiet threshold may be written whenever the block is
// idle.
module sliding_window_rms_meter_top import swrm_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_write_en,
  input  logic [SUM_W-1:0]           cfg_write_data,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic signed [SAMPLE_W-1:0] sample,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [LEVEL_W-1:0]         loudness_level
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_SUB,
    S_START,
    S_WAIT
  } state_t;

  state_t state;

  // Ring of squares
  logic [SQ_W-1:0] ring [WINDOW_DEPTH];
  logic [SQ_W-1:0] rd_data;

  logic [AW-1:0]    wp;
  logic             full;
  logic             old_valid;
  logic [SQ_W-1:0]  sq;
  logic [SQ_W-1:0]  old;
  logic [SUM_W-1:0] sum;
  logic [SUM_W-1:0] thresh;

  logic [AW-1:0]      wp_next;
  logic [SAMPLE_W:0]  mag;
  logic [2*SAMPLE_W+1:0] sq_full;
  logic [SQ_W-1:0]    sq_next;
  logic [SUM_W:0]     sum_add;
  logic [SUM_W-1:0]   sum_sat;
  logic [SUM_W-1:0]   sum_sub;
  logic [LEVEL_W-1:0] level_clamped;
  logic               in_acc;
  logic               out_free;
  logic               out_load;

  swrm_sqrt_req_t sqrt_req;
  swrm_sqrt_rsp_t sqrt_rsp;

  assign in_ready = (state == S_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;
  assign out_load = (state == S_WAIT) && sqrt_rsp.done && out_free;

  // Sample magnitude and square
  always_comb begin
    if (sample[SAMPLE_W-1]) begin
      mag = (SAMPLE_W+1)'(1 << SAMPLE_W) - {1'b0, sample};
    end else begin
      mag = {1'b0, sample};
    end
    sq_full = mag * mag;
    sq_next = sq_full[SQ_W-1:0];
    wp_next = (wp == AW'(WINDOW_DEPTH - 1)) ? '0 : wp + 1'b1;
  end

  // Saturating add, then floor-at-zero subtract of the oldest square
  always_comb begin
    sum_add = {1'b0, sum} + (SUM_W+1)'(sq);
    sum_sat = sum_add[SUM_W] ? SUM_MAX : sum_add[SUM_W-1:0];
    sum_sub = (sum >= SUM_W'(old)) ? sum - SUM_W'(old) : '0;
  end

  // Level clamp
  always_comb begin
    if (sqrt_rsp.root > ROOT_W'(LEVEL_ONE)) begin
      level_clamped = LEVEL_ONE;
    end else begin
      level_clamped = LEVEL_W'(sqrt_rsp.root);
    end
  end

  assign sqrt_req.start    = (state == S_START);
  assign sqrt_req.radicand = RAD_W'(sum >> AW);

  // Ring memory: write the new square, read the entry after it
  always_ff @(posedge clk) begin
    if (in_acc) begin
      ring[wp] <= sq_next;
    end
    rd_data <= ring[wp_next];
  end

  // Threshold register
  always_ff @(posedge clk) begin
    if (rst) begin
      thresh <= THRESH_RESET;
    end else if (cfg_write_en) begin
      thresh <= cfg_write_data;
    end
  end

  // Sequencer, sum and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      wp        <= '0;
      full      <= 1'b0;
      sum       <= '0;
      out_valid <= 1'b0;
    end else begin
      // load a new level, or retire the one just taken
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_acc) begin
            sq        <= sq_next;
            old_valid <= full || (wp == AW'(WINDOW_DEPTH - 1));
            if (wp == AW'(WINDOW_DEPTH - 1)) begin
              full <= 1'b1;
            end
            wp    <= wp_next;
            state <= S_READ;
          end
        end
        S_READ: begin
          sum   <= sum_sat;
          old   <= old_valid ? rd_data : '0;
          state <= S_SUB;
        end
        S_SUB: begin
          if (sum > thresh) begin
            sum <= sum_sub;
          end
          state <= S_START;
        end
        S_START: begin
          state <= S_WAIT;
        end
        S_WAIT: begin
          if (out_load) begin
            loudness_level <= level_clamped;
            state          <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  swrm_sqrt u_sqrt (
    .clk (clk),
    .rst (rst),
    .req (sqrt_req),
    .rsp (sqrt_rsp)
  );

endmodule

@@ hdl/swrm_checker.sv @@
// ----------------------------------------------------------------------------
// swrm_checker
// Port-level checks for the RMS level meter, bound to the top level.
// ----------------------------------------------------------------------------
module swrm_checker import swrm_pkg::*; (
  input logic                       clk,
  input logic                       rst,
  input logic                       cfg_write_en,
  input logic [SUM_W-1:0]           cfg_write_data,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic signed [SAMPLE_W-1:0] sample,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [LEVEL_W-1:0]         loudness_level
);

  // A stalled level holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(loudness_level))
    else $error("level changed or dropped while stalled");

  // Level never exceeds 1.0
  a_level_max: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> loudness_level <= LEVEL_ONE)
    else $error("level above 1.0");

  // No level right after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("level present after reset");

  // One item at a time: busy right after taking an item
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("item taken while previous one in work");

endmodule

bind sliding_window_rms_meter_top swrm_checker u_swrm_checker (.*);

@@ tb/sliding_window_rms_meter_top_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sliding_window_rms_meter_top_tb
// Self-checking bench for the sliding-window RMS level meter.
// ----------------------------------------------------------------------------
// Samples are fed over a valid/ready channel. A local model of the square
// ring, the running sum of squares and the quiet threshold works out the
// level for each accepted item, and every level leaving the block is checked
// in order against it. The tests cover the sample extremes, a fill of the
// whole ring up to its first wrap, then a zero threshold and a sweep of
// quiet thresholds while old squares leave the window, the last three under
// changing patterns of sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module sliding_window_rms_meter_top_tb;
  import swrm_pkg::*;

  localparam int CLK_HALF     = 6;
  localparam int RESET_CYCLES = 8;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int DRAIN_CYCLES = 40;
  localparam int FLOOR_ITEMS  = 12;
  localparam int SWEEP_ITEMS  = 5;

  // Largest quiet threshold in range: 2^40
  localparam logic [SUM_W-1:0] THRESH_TOP = SUM_W'(64'd1 << 40);

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic [LEVEL_W-1:0]         level_t;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  logic             clk            = 1'b0;
  logic             rst            = 1'b1;
  logic             cfg_write_en   = 1'b0;
  logic [SUM_W-1:0] cfg_write_data = '0;
  logic             in_valid       = 1'b0;
  logic             in_ready;
  sample_t          sample         = '0;
  logic             out_valid;
  logic             out_ready      = 1'b0;
  level_t           loudness_level;

  // Model state: ring of squares, running sum, write slot, threshold
  logic [SQ_W-1:0]  ring_sq [WINDOW_DEPTH];
  logic [SUM_W-1:0] sum_sq;
  int unsigned      ring_wr;
  logic [SUM_W-1:0] quiet_thresh;

  level_t      expected_levels[$];
  int          errors         = 0;
  int unsigned cycles         = 0;
  int          send_idle_pct  = 0;
  int          recv_stall_pct = 0;

  sliding_window_rms_meter_top u_top (
    .clk            (clk),
    .rst            (rst),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .sample         (sample),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .loudness_level (loudness_level)
  );

  // Clock
  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  // Run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("sliding_window_rms_meter_top: mismatch");
      $finish;
    end
  end

  // Level receiver: check each accepted item, then pick the next ready
  always @(posedge clk) begin : check_levels
    level_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_levels.size() == 0) begin
        $display("%0t: loudness_level expected none, got %0d", $time, loudness_level);
        errors++;
      end else begin
        want = expected_levels.pop_front();
        if (loudness_level !== want) begin
          $display("%0t: loudness_level expected %0d, got %0d",
                   $time, want, loudness_level);
          errors++;
        end
      end
    end
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic model_reset();
    foreach (ring_sq[i]) ring_sq[i] = '0;
    sum_sq       = '0;
    ring_wr      = 0;
    quiet_thresh = THRESH_RESET;
  endtask

  // Advance the model by one sample and return the level it gives
  function automatic level_t predict_level(input sample_t s);
    int                mag;
    int                b;
    logic [SQ_W-1:0]   sq;
    logic [SQ_W-1:0]   oldest;
    longint unsigned   acc;
    longint unsigned   mean;
    longint unsigned   root;
    longint unsigned   trial;
    mag = (s < 0) ? -int'(s) : int'(s);
    sq  = SQ_W'(mag * mag);
    acc = longint'(sum_sq) + longint'(sq);
    sum_sq = (acc > longint'(SUM_MAX)) ? SUM_MAX : SUM_W'(acc);
    ring_sq[ring_wr] = sq;
    ring_wr = (ring_wr + 1) % WINDOW_DEPTH;
    // above the quiet threshold the oldest square leaves the window
    if (sum_sq > quiet_thresh) begin
      oldest = ring_sq[ring_wr];
      sum_sq = (sum_sq >= oldest) ? sum_sq - oldest : '0;
    end
    // floor of sqrt(sum / window), bit by bit
    mean = longint'(sum_sq) / WINDOW_DEPTH;
    root = 0;
    for (b = 16; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= mean) root = trial;
    end
    return (root > LEVEL_ONE) ? LEVEL_ONE : level_t'(root);
  endfunction

  task automatic set_idle(input idle_mode_t mode);
    case (mode)
      IDLE_SENDER: begin
        send_idle_pct  = 87;
        recv_stall_pct = 0;
      end
      IDLE_RECEIVER: begin
        send_idle_pct  = 0;
        recv_stall_pct = 87;
      end
      IDLE_BOTH: begin
        send_idle_pct  = 23;
        recv_stall_pct = 23;
      end
      default: begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
    endcase
  endtask

  // Present one sample and hold it until accepted; valid stays up afterward
  // so back-to-back items need no gap in between
  task automatic send_sample(input sample_t s);
    int gap;
    gap = 0;
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    sample   <= s;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_levels.push_back(predict_level(s));
  endtask

  // Threshold writes only once every pending level has come out
  task automatic write_threshold(input logic [SUM_W-1:0] value);
    in_valid <= 1'b0;
    while (expected_levels.size() != 0) @(posedge clk);
    cfg_write_en   <= 1'b1;
    cfg_write_data <= value;
    @(posedge clk);
    cfg_write_en <= 1'b0;
    quiet_thresh = value;
  endtask

  function automatic sample_t near_full();
    int mag;
    mag = $urandom_range(32768, 32400);
    if (mag == 32768 || $urandom_range(1)) return sample_t'(-mag);
    return sample_t'(mag);
  endfunction

  function automatic sample_t near_quiet();
    int mag;
    mag = $urandom_range(64);
    return $urandom_range(1) ? sample_t'(-mag) : sample_t'(mag);
  endfunction

  function automatic sample_t mixed_sample();
    case ($urandom_range(2))
      0:       return near_full();
      1:       return near_quiet();
      default: return sample_t'($urandom);
    endcase
  endfunction

  // Sample extremes and bit patterns at the reset threshold
  task automatic test_field_extremes();
    sample_t picks[14] = '{16'h0000, 16'h7FFF, 16'h8000, 16'h8001, 16'h0001,
                           16'hFFFF, 16'h5555, 16'hAAAA, 16'h00FF, 16'hFF00,
                           16'h4000, 16'hC000, 16'h0000, 16'h0000};
    set_idle(IDLE_NONE);
    foreach (picks[i]) send_sample(picks[i]);
  endtask

  // Fill the whole ring: loud samples up to the middle, mixed ones up to
  // the wrap, where the first squares start to leave the window
  task automatic test_window_fill();
    set_idle(IDLE_SENDER);
    while (ring_wr != WINDOW_DEPTH / 2) send_sample(near_full());
    set_idle(IDLE_RECEIVER);
    while (ring_wr != 0) send_sample(mixed_sample());
  endtask

  // Zero threshold: the oldest square is always subtracted
  task automatic test_threshold_zero();
    write_threshold('0);
    set_idle(IDLE_BOTH);
    repeat (FLOOR_ITEMS) send_sample(sample_t'($urandom));
  endtask

  // Threshold sweep across the range, one idle pattern per setting
  task automatic test_threshold_sweep();
    logic [SUM_W-1:0] thresholds[5];
    thresholds[0] = THRESH_TOP - 1;
    thresholds[1] = {1'b0, 8'($urandom), 32'($urandom)};
    thresholds[2] = THRESH_RESET;
    thresholds[3] = {1'b0, 8'($urandom), 32'($urandom)};
    thresholds[4] = THRESH_TOP;
    foreach (thresholds[k]) begin
      write_threshold(thresholds[k]);
      set_idle(idle_mode_t'(k % 4));
      repeat (SWEEP_ITEMS) send_sample(mixed_sample());
    end
  endtask

  initial begin
    model_reset();
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    test_field_extremes();
    test_window_fill();
    test_threshold_zero();
    test_threshold_sweep();

    // drain the remaining levels
    set_idle(IDLE_NONE);
    in_valid <= 1'b0;
    while (expected_levels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("sliding_window_rms_meter_top: match");
    end else begin
      $display("sliding_window_rms_meter_top: mismatch");
    end
    $finish;
  end

endmodule

@@ files.f @@
hdl/swrm_pkg.sv
hdl/swrm_sqrt.sv
hdl/sliding_window_rms_meter_top.sv
hdl/swrm_checker.sv
tb/sliding_window_rms_meter_top_tb.sv
